// ----- rtl/tsf_pkg.sv -----
package tsf_pkg;

  // symbol codes, low nibble of a digit code; bit 4 is the dot request
  localparam logic [3:0] SYM_BLANK  = 4'd0;
  localparam logic [3:0] SYM_DIGIT0 = 4'd1;
  localparam logic [3:0] SYM_D      = 4'd11;
  localparam logic [3:0] SYM_H      = 4'd12;
  localparam logic [3:0] SYM_N      = 4'd13;

  localparam logic [13:0] DAYS_MAX   = 14'd9999;
  localparam logic [4:0]  HOURS_MAX  = 5'd23;
  localparam logic [5:0]  MINSEC_MAX = 6'd59;
  localparam logic [9:0]  MILLIS_MAX = 10'd999;

  localparam logic [1:0] GRP_DAYS    = 2'd0;
  localparam logic [1:0] GRP_HOURS   = 2'd1;
  localparam logic [1:0] GRP_SECONDS = 2'd2;

  localparam int QDEPTH = 2;

  typedef enum logic [1:0] {
    REG_DISPLAY_MODE = 2'd0,
    REG_DAYS_VIS     = 2'd1,
    REG_HOURS_VIS    = 2'd2,
    REG_SECONDS_VIS  = 2'd3
  } cfg_reg_t;

  typedef logic [4:0] code_t;

  typedef struct packed {
    logic [3:0] tens;
    logic [3:0] ones;
  } tens_t;

  // first front stage: clamped fields, thousands of days and tenths of a second split off
  typedef struct packed {
    logic [3:0] d1000;
    logic [9:0] days_rem;
    logic       bd;
    logic [4:0] hours;
    logic [5:0] mins;
    logic [5:0] secs;
    logic [3:0] u100;
  } fstage_t;

  // decoded item as queued for the back end
  typedef struct packed {
    logic [3:0] d1000;
    logic [3:0] d100;
    logic [3:0] d10;
    logic [3:0] d1;
    logic [3:0] h10;
    logic [3:0] h1;
    logic [3:0] m10;
    logic [3:0] m1;
    logic [3:0] s10;
    logic [3:0] s1;
    logic [3:0] u100;
    logic       bd;
    logic       bh;
    logic       bmin;
    logic       bsec;
  } digits_t;

  typedef struct packed {
    logic [2:0] mode;
    logic [2:0] vis;
  } cfg_t;

  function automatic tens_t split_tens(input logic [6:0] v);
    tens_t r;
    r.tens = 4'd0;
    for (int k = 1; k < 10; k++) begin
      if (v >= 7'(k * 10)) r.tens = 4'(k);
    end
    r.ones = 4'(v - 7'(r.tens) * 7'd10);
    return r;
  endfunction

  function automatic code_t dig(input logic [3:0] n, input logic vis, input logic dot);
    logic [3:0] s;
    s = vis ? 4'(SYM_DIGIT0 + n) : SYM_BLANK;
    return {dot, s};
  endfunction

  function automatic code_t chr(input logic [3:0] sym, input logic vis);
    return {1'b0, (vis ? sym : SYM_BLANK)};
  endfunction

  function automatic logic [6:0] glyph(input logic [3:0] s);
    logic [6:0] g;
    unique case (s)
      4'd1:    g = 7'h3F;
      4'd2:    g = 7'h06;
      4'd3:    g = 7'h5B;
      4'd4:    g = 7'h4F;
      4'd5:    g = 7'h66;
      4'd6:    g = 7'h6D;
      4'd7:    g = 7'h7D;
      4'd8:    g = 7'h07;
      4'd9:    g = 7'h7F;
      4'd10:   g = 7'h6F;
      SYM_D:   g = 7'h5E;
      SYM_H:   g = 7'h74;
      SYM_N:   g = 7'h54;
      default: g = 7'h00;
    endcase
    return g;
  endfunction

  // blank symbol hides its dot request as well
  function automatic logic [7:0] pattern(input code_t c);
    logic [6:0] g;
    g = glyph(c[3:0]);
    if (g == 7'h00) return 8'h00;
    return {c[4], g};
  endfunction

endpackage

// ----- rtl/time_to_seven_segment_formatter_top.sv -----
// Countdown time to seven-segment formatter. Each accepted item (days, hours,
// minutes, seconds, millis) yields three items on the output channel in the
// order days, hours-minutes, seconds group, the last flagged by
// out_last_group. The back end renders one group per cycle while out_stall is
// low; the front end takes new items while earlier ones are still rendered. A
// two-stage front end clamps the fields and splits them into decimal digits,
// then hands the item to a two-entry queue; the back end takes it from the
// queue and registers each group on the output. Configuration writes are always
// ready and take effect for groups rendered afterwards.
module time_to_seven_segment_formatter_top import tsf_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [13:0] in_days,
  input  logic [4:0]  in_hours,
  input  logic [5:0]  in_minutes,
  input  logic [5:0]  in_seconds,
  input  logic [9:0]  in_millis,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_group,
  output logic [7:0]  out_left_digit,
  output logic [7:0]  out_second_digit,
  output logic [7:0]  out_third_digit,
  output logic [7:0]  out_right_digit,
  output logic        out_colon_on,
  output logic        out_group_changed,
  output logic        out_last_group,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [2:0]  cfg_data
);

  cfg_t    cfg_r, cfg_nxt;
  logic    push, q_full, pop, q_valid;
  digits_t push_data, q_data;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_DISPLAY_MODE: cfg_nxt.mode   = cfg_data;
        REG_DAYS_VIS:     cfg_nxt.vis[0] = cfg_data[0];
        REG_HOURS_VIS:    cfg_nxt.vis[1] = cfg_data[0];
        REG_SECONDS_VIS:  cfg_nxt.vis[2] = cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mode <= 3'd0;
      cfg_r.vis  <= 3'b111;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  tsf_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_days    (in_days),
    .in_hours   (in_hours),
    .in_minutes (in_minutes),
    .in_seconds (in_seconds),
    .in_millis  (in_millis),
    .push       (push),
    .push_data  (push_data),
    .q_full     (q_full)
  );

  tsf_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .q_valid   (q_valid),
    .q_data    (q_data)
  );

  tsf_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (cfg_r),
    .q_valid           (q_valid),
    .q_data            (q_data),
    .pop               (pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_group         (out_group),
    .out_left_digit    (out_left_digit),
    .out_second_digit  (out_second_digit),
    .out_third_digit   (out_third_digit),
    .out_right_digit   (out_right_digit),
    .out_colon_on      (out_colon_on),
    .out_group_changed (out_group_changed),
    .out_last_group    (out_last_group)
  );

endmodule

// ----- rtl/tsf_front.sv -----
module tsf_front import tsf_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [13:0] in_days,
  input  logic [4:0]  in_hours,
  input  logic [5:0]  in_minutes,
  input  logic [5:0]  in_seconds,
  input  logic [9:0]  in_millis,
  output logic        push,
  output digits_t     push_data,
  input  logic        q_full
);

  logic    fr_valid_r, fr_valid_nxt;
  fstage_t fr_r, fr_nxt;
  logic    accept;

  logic [13:0] days_c;
  logic [9:0]  ms_c;
  logic [9:0]  rem;
  logic [6:0]  rem100;
  logic [3:0]  d100;
  tens_t       t_d, t_h, t_m, t_s;

  assign in_stall = fr_valid_r && q_full;
  assign accept   = in_valid && !in_stall;
  assign push     = fr_valid_r && !q_full;

  // stage 1: clamp, split off thousands of days and the tenths of a second
  always_comb begin
    days_c = (in_days > DAYS_MAX) ? DAYS_MAX : in_days;
    ms_c   = (in_millis > MILLIS_MAX) ? MILLIS_MAX : in_millis;
    fr_nxt.d1000 = 4'd0;
    for (int k = 1; k < 10; k++) begin
      if (days_c >= 14'(k * 1000)) fr_nxt.d1000 = 4'(k);
    end
    fr_nxt.days_rem = 10'(days_c - 14'(fr_nxt.d1000) * 14'd1000);
    fr_nxt.bd       = (days_c != 14'd0);
    fr_nxt.u100     = 4'd0;
    for (int k = 1; k < 10; k++) begin
      if (ms_c >= 10'(k * 100)) fr_nxt.u100 = 4'(k);
    end
    fr_nxt.hours = (in_hours > HOURS_MAX) ? HOURS_MAX : in_hours;
    fr_nxt.mins  = (in_minutes > MINSEC_MAX) ? MINSEC_MAX : in_minutes;
    fr_nxt.secs  = (in_seconds > MINSEC_MAX) ? MINSEC_MAX : in_seconds;
  end

  always_comb begin
    fr_valid_nxt = fr_valid_r;
    if (accept)    fr_valid_nxt = 1'b1;
    else if (push) fr_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fr_valid_r <= 1'b0;
    end else begin
      fr_valid_r <= fr_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      fr_r <= fr_nxt;
    end
  end

  // stage 2: remaining decimal digits
  always_comb begin
    rem  = fr_r.days_rem;
    d100 = 4'd0;
    for (int k = 1; k < 10; k++) begin
      if (rem >= 10'(k * 100)) d100 = 4'(k);
    end
    rem100 = 7'(rem - 10'(d100) * 10'd100);
    t_d = split_tens(rem100);
    t_h = split_tens(7'(fr_r.hours));
    t_m = split_tens(7'(fr_r.mins));
    t_s = split_tens(7'(fr_r.secs));

    push_data.d1000 = fr_r.d1000;
    push_data.d100  = d100;
    push_data.d10   = t_d.tens;
    push_data.d1    = t_d.ones;
    push_data.h10   = t_h.tens;
    push_data.h1    = t_h.ones;
    push_data.m10   = t_m.tens;
    push_data.m1    = t_m.ones;
    push_data.s10   = t_s.tens;
    push_data.s1    = t_s.ones;
    push_data.u100  = fr_r.u100;
    push_data.bd    = fr_r.bd;
    push_data.bh    = (fr_r.hours != 5'd0);
    push_data.bmin  = (fr_r.mins != 6'd0);
    push_data.bsec  = (fr_r.secs != 6'd0);
  end

endmodule

// ----- rtl/tsf_queue.sv -----
module tsf_queue import tsf_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  digits_t push_data,
  output logic    full,
  input  logic    pop,
  output logic    q_valid,
  output digits_t q_data
);

  localparam int PW = $clog2(QDEPTH);
  localparam int CW = $clog2(QDEPTH + 1);

  digits_t       mem_r [QDEPTH];
  logic [PW-1:0] wr_r, wr_nxt, rd_r, rd_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  assign full    = (cnt_r == CW'(QDEPTH));
  assign q_valid = (cnt_r != '0);
  assign q_data  = mem_r[rd_r];

  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (push) wr_nxt = (wr_r == PW'(QDEPTH - 1)) ? '0 : PW'(wr_r + 1'b1);
    if (pop)  rd_nxt = (rd_r == PW'(QDEPTH - 1)) ? '0 : PW'(rd_r + 1'b1);
    if (push && !pop)      cnt_nxt = CW'(cnt_r + 1'b1);
    else if (pop && !push) cnt_nxt = CW'(cnt_r - 1'b1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= push_data;
    end
  end

endmodule

// ----- rtl/tsf_back.sv -----
module tsf_back import tsf_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  cfg_t       cfg,
  input  logic       q_valid,
  input  digits_t    q_data,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] out_group,
  output logic [7:0] out_left_digit,
  output logic [7:0] out_second_digit,
  output logic [7:0] out_third_digit,
  output logic [7:0] out_right_digit,
  output logic       out_colon_on,
  output logic       out_group_changed,
  output logic       out_last_group
);

  logic [1:0] grp_r, grp_nxt;
  logic       out_valid_r, out_valid_nxt;
  code_t      prev_sym_r [3][4];
  logic [2:0] prev_col_r;
  code_t      cur [4];      // index 0 rightmost
  logic       colon;
  logic       changed;
  logic       adv;

  logic [1:0] grp_r_o;
  logic [7:0] left_r, second_r, third_r, right_r;
  logic       colon_r, changed_r, last_r;

  digits_t    d;
  logic [2:0] mode;
  logic       any_dh, upm, ups, days_big, d_nz;

  assign adv = q_valid && (!out_valid_r || !out_stall);
  assign pop = adv && (grp_r == GRP_SECONDS);
  assign d    = q_data;
  assign mode = cfg.mode;

  always_comb begin
    any_dh   = d.bd || d.bh;
    upm      = d.bd || d.bh || d.bmin;
    ups      = upm || d.bsec;
    days_big = (d.d1000 != 4'd0) || (d.d100 != 4'd0);
    d_nz     = (d.d10 != 4'd0) || (d.d1 != 4'd0);
    for (int i = 0; i < 4; i++) cur[i] = '0;
    colon = 1'b0;
    if (cfg.vis[grp_r]) begin
      unique case (grp_r)
        GRP_DAYS: begin
          if (days_big) begin
            cur[3] = dig(d.d1000, d.d1000 != 4'd0, 1'b0);
            cur[2] = dig(d.d100, 1'b1, 1'b0);
            cur[1] = dig(d.d10, 1'b1, 1'b0);
            cur[0] = dig(d.d1, 1'b1, 1'b0);
          end else if (!mode[2]) begin
            cur[3] = dig(d.d10, d.d10 != 4'd0, 1'b0);
            cur[2] = dig(d.d1, d_nz, 1'b0);
            cur[0] = chr(SYM_D, d_nz);
          end else begin
            cur[1] = dig(d.d10, d.d10 != 4'd0, 1'b0);
            cur[0] = dig(d.d1, d_nz, 1'b0);
          end
        end
        GRP_HOURS: begin
          if (!mode[1]) begin
            cur[3] = dig(d.h10, d.h10 != 4'd0, 1'b0);
            cur[2] = dig(d.h1, upm, 1'b0);
            cur[1] = dig(d.m10, upm, 1'b0);
            cur[0] = dig(d.m1, upm, 1'b0);
            colon  = upm;
          end else if (!mode[2]) begin
            cur[3] = dig(d.h10, d.h10 != 4'd0, 1'b0);
            cur[2] = dig(d.h1, any_dh, 1'b0);
            cur[0] = chr(SYM_H, any_dh);
          end else begin
            cur[1] = dig(d.h10, d.h10 != 4'd0, 1'b0);
            cur[0] = dig(d.h1, any_dh, 1'b0);
          end
        end
        GRP_SECONDS: begin
          unique case (mode[1:0])
            2'b00: begin
              cur[2] = dig(d.s10, d.s10 != 4'd0, 1'b0);
              cur[1] = dig(d.s1, 1'b1, 1'b1);
              cur[0] = dig(d.u100, 1'b1, 1'b0);
            end
            2'b01: begin
              cur[1] = dig(d.s10, d.s10 != 4'd0, 1'b0);
              cur[0] = dig(d.s1, 1'b1, 1'b0);
            end
            2'b10: begin
              cur[3] = dig(d.m10, d.m10 != 4'd0, 1'b0);
              cur[2] = dig(d.m1, upm, 1'b0);
              cur[1] = dig(d.s10, upm || (d.s10 != 4'd0), 1'b0);
              cur[0] = dig(d.s1, ups, 1'b0);
              colon  = upm;
            end
            default: begin
              // blinking dot on the minutes units digit
              if (!mode[2]) begin
                cur[3] = dig(d.m10, d.m10 != 4'd0, 1'b0);
                cur[2] = dig(d.m1, ups, d.u100 < 4'd5);
                cur[0] = chr(SYM_N, ups);
              end else begin
                cur[1] = dig(d.m10, d.m10 != 4'd0, 1'b0);
                cur[0] = dig(d.m1, ups, d.u100 < 4'd5);
              end
            end
          endcase
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    changed = (colon != prev_col_r[grp_r]);
    for (int i = 0; i < 4; i++) begin
      if (cur[i] != prev_sym_r[grp_r][i]) changed = 1'b1;
    end
  end

  always_comb begin
    grp_nxt = grp_r;
    if (adv) grp_nxt = (grp_r == GRP_SECONDS) ? GRP_DAYS : 2'(grp_r + 1'b1);
    out_valid_nxt = adv ? 1'b1 : (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grp_r       <= GRP_DAYS;
      out_valid_r <= 1'b0;
      prev_col_r  <= '0;
      for (int g = 0; g < 3; g++) begin
        for (int i = 0; i < 4; i++) prev_sym_r[g][i] <= '0;
      end
    end else begin
      grp_r       <= grp_nxt;
      out_valid_r <= out_valid_nxt;
      if (adv) begin
        prev_col_r[grp_r] <= colon;
        for (int i = 0; i < 4; i++) prev_sym_r[grp_r][i] <= cur[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      grp_r_o   <= grp_r;
      left_r    <= pattern(cur[3]);
      second_r  <= pattern(cur[2]);
      third_r   <= pattern(cur[1]);
      right_r   <= pattern(cur[0]);
      colon_r   <= colon;
      changed_r <= changed;
      last_r    <= (grp_r == GRP_SECONDS);
    end
  end

  assign out_valid         = out_valid_r;
  assign out_group         = grp_r_o;
  assign out_left_digit    = left_r;
  assign out_second_digit  = second_r;
  assign out_third_digit   = third_r;
  assign out_right_digit   = right_r;
  assign out_colon_on      = colon_r;
  assign out_group_changed = changed_r;
  assign out_last_group    = last_r;

endmodule

// ----- test/seg_group_checker.sv -----
`timescale 1ns / 1ps

module seg_group_checker import tsf_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [13:0] in_days,
  input  logic [4:0]  in_hours,
  input  logic [5:0]  in_minutes,
  input  logic [5:0]  in_seconds,
  input  logic [9:0]  in_millis,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [1:0]  out_group,
  input  logic [7:0]  out_left_digit,
  input  logic [7:0]  out_second_digit,
  input  logic [7:0]  out_third_digit,
  input  logic [7:0]  out_right_digit,
  input  logic        out_colon_on,
  input  logic        out_group_changed,
  input  logic        out_last_group,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [2:0]  cfg_data,
  output int          mismatch_count,
  output int          groups_pending
);

  // low two mode bits pick the seconds-group layout, bit 2 drops the letters
  localparam logic [1:0] LAY_TENTHS  = 2'd0;
  localparam logic [1:0] LAY_SECONDS = 2'd1;
  localparam logic [1:0] LAY_MMSS    = 2'd2;

  // segments a..g per symbol code, blank first
  localparam logic [0:13][6:0] SEG_FONT = {
    7'h00, 7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07, 7'h7F, 7'h6F,
    7'h5E, 7'h74, 7'h54
  };

  typedef struct packed {
    logic [1:0] grp;
    logic [7:0] left_seg;
    logic [7:0] second_seg;
    logic [7:0] third_seg;
    logic [7:0] right_seg;
    logic       colon;
    logic       changed;
    logic       last_grp;
  } seg_group_t;

  seg_group_t expected_groups[$];
  logic [2:0] layout_mode;
  logic [2:0] group_shown;
  code_t      shown_codes [12];
  logic       shown_colons [3];

  function automatic code_t digit_code(input int n, input bit shown, input bit dot);
    return {dot, shown ? 4'(SYM_DIGIT0 + n) : SYM_BLANK};
  endfunction

  function automatic code_t char_code(input logic [3:0] s, input bit shown);
    return {1'b0, shown ? s : SYM_BLANK};
  endfunction

  // a blank symbol shows nothing, not even its dot
  function automatic logic [7:0] seg_pattern(input code_t c);
    if (c[3:0] == SYM_BLANK || c[3:0] > SYM_N) return 8'h00;
    return {c[4], SEG_FONT[c[3:0]]};
  endfunction

  task automatic predict_groups(input logic [13:0] d_in, input logic [4:0] h_in,
                                input logic [5:0] m_in, input logic [5:0] s_in,
                                input logic [9:0] ms_in);
    int days, hours, mins, secs, tenths;
    int d1000, d100, d10, d1, h10, h1, m10, m1, s10, s1;
    bit bd, bh, up_min, up_sec, compact, colon, changed;
    logic [1:0] lay;
    code_t sym [4];
    seg_group_t r;
    int g, k;
    days   = (d_in > DAYS_MAX) ? int'(DAYS_MAX) : int'(d_in);
    hours  = (h_in > HOURS_MAX) ? int'(HOURS_MAX) : int'(h_in);
    mins   = (m_in > MINSEC_MAX) ? int'(MINSEC_MAX) : int'(m_in);
    secs   = (s_in > MINSEC_MAX) ? int'(MINSEC_MAX) : int'(s_in);
    tenths = ((ms_in > MILLIS_MAX) ? int'(MILLIS_MAX) : int'(ms_in)) / 100;
    d1000 = days / 1000;
    d100  = (days % 1000) / 100;
    d10   = (days % 100) / 10;
    d1    = days % 10;
    h10 = hours / 10;
    h1  = hours % 10;
    m10 = mins / 10;
    m1  = mins % 10;
    s10 = secs / 10;
    s1  = secs % 10;
    bd = days != 0;
    bh = hours != 0;
    up_min = bd || bh || mins != 0;
    up_sec = up_min || secs != 0;
    compact = layout_mode[2];
    lay = layout_mode[1:0];

    for (g = 0; g < 3; g++) begin
      for (k = 0; k < 4; k++) sym[k] = '0;
      colon = 1'b0;
      changed = 1'b0;
      if (group_shown[g]) begin
        case (g)
          GRP_DAYS: begin
            if (d1000 != 0 || d100 != 0) begin
              sym[3] = digit_code(d1000, d1000 != 0, 1'b0);
              sym[2] = digit_code(d100, 1'b1, 1'b0);
              sym[1] = digit_code(d10, 1'b1, 1'b0);
              sym[0] = digit_code(d1, 1'b1, 1'b0);
            end else if (!compact) begin
              sym[3] = digit_code(d10, d10 != 0, 1'b0);
              sym[2] = digit_code(d1, bd, 1'b0);
              sym[0] = char_code(SYM_D, bd);
            end else begin
              sym[1] = digit_code(d10, d10 != 0, 1'b0);
              sym[0] = digit_code(d1, bd, 1'b0);
            end
          end
          GRP_HOURS: begin
            if (!lay[1]) begin
              sym[3] = digit_code(h10, h10 != 0, 1'b0);
              sym[2] = digit_code(h1, up_min, 1'b0);
              sym[1] = digit_code(m10, up_min, 1'b0);
              sym[0] = digit_code(m1, up_min, 1'b0);
              colon = up_min;
            end else if (!compact) begin
              sym[3] = digit_code(h10, h10 != 0, 1'b0);
              sym[2] = digit_code(h1, bd || bh, 1'b0);
              sym[0] = char_code(SYM_H, bd || bh);
            end else begin
              sym[1] = digit_code(h10, h10 != 0, 1'b0);
              sym[0] = digit_code(h1, bd || bh, 1'b0);
            end
          end
          default: begin
            case (lay)
              LAY_TENTHS: begin
                sym[2] = digit_code(s10, s10 != 0, 1'b0);
                sym[1] = digit_code(s1, 1'b1, 1'b1);
                sym[0] = digit_code(tenths, 1'b1, 1'b0);
              end
              LAY_SECONDS: begin
                sym[1] = digit_code(s10, s10 != 0, 1'b0);
                sym[0] = digit_code(s1, 1'b1, 1'b0);
              end
              LAY_MMSS: begin
                sym[3] = digit_code(m10, m10 != 0, 1'b0);
                sym[2] = digit_code(m1, up_min, 1'b0);
                sym[1] = digit_code(s10, up_min || s10 != 0, 1'b0);
                sym[0] = digit_code(s1, up_sec, 1'b0);
                colon = up_min;
              end
              default: begin
                // minutes only; the units dot blinks with the tenths
                if (!compact) begin
                  sym[3] = digit_code(m10, m10 != 0, 1'b0);
                  sym[2] = digit_code(m1, up_sec, tenths < 5);
                  sym[0] = char_code(SYM_N, up_sec);
                end else begin
                  sym[1] = digit_code(m10, m10 != 0, 1'b0);
                  sym[0] = digit_code(m1, up_sec, tenths < 5);
                end
              end
            endcase
          end
        endcase
      end

      // dot requests on blanked digits count here even though they stay dark
      for (k = 0; k < 4; k++) begin
        if (shown_codes[g * 4 + k] != sym[k]) changed = 1'b1;
        shown_codes[g * 4 + k] = sym[k];
      end
      if (shown_colons[g] != colon) changed = 1'b1;
      shown_colons[g] = colon;

      r.grp        = 2'(g);
      r.left_seg   = seg_pattern(sym[3]);
      r.second_seg = seg_pattern(sym[2]);
      r.third_seg  = seg_pattern(sym[1]);
      r.right_seg  = seg_pattern(sym[0]);
      r.colon      = colon;
      r.changed    = changed;
      r.last_grp   = (g == GRP_SECONDS);
      expected_groups.push_back(r);
    end
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    seg_group_t want;
    if (!rst_n) begin
      layout_mode = 3'd0;
      group_shown = 3'b111;
      foreach (shown_codes[k]) shown_codes[k] = '0;
      foreach (shown_colons[k]) shown_colons[k] = 1'b0;
      expected_groups.delete();
      mismatch_count = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_reg_t'(cfg_index))
          REG_DISPLAY_MODE: layout_mode = cfg_data;
          REG_DAYS_VIS:     group_shown[GRP_DAYS] = cfg_data[0];
          REG_HOURS_VIS:    group_shown[GRP_HOURS] = cfg_data[0];
          REG_SECONDS_VIS:  group_shown[GRP_SECONDS] = cfg_data[0];
        endcase
      end
      if (out_valid && !out_stall) begin
        if (expected_groups.size() == 0) begin
          $error("group %0d item arrived with nothing expected", out_group);
          mismatch_count++;
        end else begin
          want = expected_groups.pop_front();
          check_field("group", want.grp, out_group);
          check_field("left_digit", want.left_seg, out_left_digit);
          check_field("second_digit", want.second_seg, out_second_digit);
          check_field("third_digit", want.third_seg, out_third_digit);
          check_field("right_digit", want.right_seg, out_right_digit);
          check_field("colon_on", want.colon, out_colon_on);
          check_field("group_changed", want.changed, out_group_changed);
          check_field("last_group", want.last_grp, out_last_group);
        end
      end
      if (in_valid && !in_stall)
        predict_groups(in_days, in_hours, in_minutes, in_seconds, in_millis);
    end
    groups_pending = expected_groups.size();
  end

endmodule

// ----- test/tb_time_to_seven_segment_formatter_top.sv -----
`timescale 1ns / 1ps

module tb_time_to_seven_segment_formatter_top;
  import tsf_pkg::*;

  localparam int HOLD_CYCLES = 60;
  localparam longint MS_PER_DAY = 86400000;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [13:0] in_days;
  logic [4:0]  in_hours;
  logic [5:0]  in_minutes;
  logic [5:0]  in_seconds;
  logic [9:0]  in_millis;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  out_group;
  logic [7:0]  out_left_digit;
  logic [7:0]  out_second_digit;
  logic [7:0]  out_third_digit;
  logic [7:0]  out_right_digit;
  logic        out_colon_on;
  logic        out_group_changed;
  logic        out_last_group;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [2:0]  cfg_data;
  int          mismatch_count;
  int          groups_pending;

  bit     in_quiet;
  bit     out_quiet;
  bit     hold_req;
  int     hold_left;
  int     stall_left;
  longint countdown_ms;

  time_to_seven_segment_formatter_top u_top (.*);

  seg_group_checker u_checker (.*);

  initial clk = 1'b0;
  always #1 clk = ~clk;

  initial begin
    #400000;
    $display("*** FAILED ***");
    $finish;
  end

  function automatic int pick_gap(input bit quiet);
    return quiet ? 0 : int'($urandom_range(0, 16));
  endfunction

  // receiver: a long hold when asked, otherwise a fresh stall per item
  always @(posedge clk) begin
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req = 1'b0;
    end
    if (out_valid && !out_stall) stall_left = pick_gap(out_quiet);
  end

  initial begin
    out_stall = 1'b0;
    hold_left = 0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_stall = 1'b1;
        hold_left--;
      end else if (stall_left > 0) begin
        out_stall = 1'b1;
        stall_left--;
      end else begin
        out_stall = 1'b0;
      end
    end
  end

  // valid stays up when the next item follows without a gap
  task automatic send_time(input logic [13:0] d, input logic [4:0] h, input logic [5:0] m,
                           input logic [5:0] s, input logic [9:0] ms);
    int gap;
    gap = pick_gap(in_quiet);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid   = 1'b1;
    in_days    = d;
    in_hours   = h;
    in_minutes = m;
    in_seconds = s;
    in_millis  = ms;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic wait_idle();
    in_valid = 1'b0;
    while (groups_pending != 0) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [2:0] val);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // shown bit 0 days, bit 1 hours-minutes, bit 2 seconds
  task automatic set_config(input logic [2:0] mode, input logic [2:0] shown);
    wait_idle();
    write_reg(REG_DISPLAY_MODE, mode);
    write_reg(REG_DAYS_VIS, {2'b00, shown[0]});
    write_reg(REG_HOURS_VIS, {2'b00, shown[1]});
    write_reg(REG_SECONDS_VIS, {2'b00, shown[2]});
  endtask

  // mostly a running countdown so groups repeat; some jumps and raw noise
  task automatic random_item();
    int pick;
    int span;
    longint t;
    logic [13:0] d;
    pick = $urandom_range(0, 9);
    if (pick < 6) begin
      if (countdown_ms < 2000 || pick == 0) begin
        span = $urandom_range(0, 3);
        case (span)
          0: d = 14'd0;
          1: d = 14'($urandom_range(1, 99));
          2: d = 14'($urandom_range(100, 9999));
          default: d = 14'($urandom_range(0, 2));
        endcase
        countdown_ms = longint'(d) * MS_PER_DAY + longint'($urandom_range(0, 86399999));
      end else begin
        t = $urandom_range(0, 1200);
        countdown_ms = (countdown_ms > t) ? countdown_ms - t : 0;
      end
      t = countdown_ms;
      send_time(14'(t / MS_PER_DAY), 5'((t / 3600000) % 24), 6'((t / 60000) % 60),
                6'((t / 1000) % 60), 10'(t % 1000));
    end else if (pick < 9) begin
      span = $urandom_range(0, 2);
      d = (span == 0) ? 14'd0 :
          (span == 1) ? 14'($urandom_range(1, 99)) : 14'($urandom_range(100, 9999));
      send_time(d, ($urandom_range(0, 2) == 0) ? 5'd0 : 5'($urandom_range(0, 23)),
                ($urandom_range(0, 2) == 0) ? 6'd0 : 6'($urandom_range(0, 59)),
                6'($urandom_range(0, 59)), 10'($urandom_range(0, 999)));
    end else begin
      send_time(14'($urandom), 5'($urandom), 6'($urandom), 6'($urandom), 10'($urandom));
    end
  endtask

  initial begin
    int offset;
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_days    = '0;
    in_hours   = '0;
    in_minutes = '0;
    in_seconds = '0;
    in_millis  = '0;
    cfg_valid  = 1'b0;
    cfg_index  = REG_DISPLAY_MODE;
    cfg_data   = '0;
    in_quiet   = 1'b0;
    out_quiet  = 1'b0;
    hold_req   = 1'b0;
    countdown_ms = 0;
    repeat (3) @(negedge clk);
    rst_n = 1'b1;

    // reset layout: extremes, saturation, leading-zero blanking
    send_time(14'd0, 5'd0, 6'd0, 6'd0, 10'd0);
    send_time(14'd9999, 5'd23, 6'd59, 6'd59, 10'd999);
    send_time(14'h3FFF, 5'h1F, 6'h3F, 6'h3F, 10'h3FF);
    send_time(14'd9999, 5'd23, 6'd59, 6'd59, 10'd999);
    send_time(14'd100, 5'd0, 6'd0, 6'd0, 10'd0);
    send_time(14'd1000, 5'd5, 6'd0, 6'd0, 10'd0);
    send_time(14'd12, 5'd0, 6'd0, 6'd0, 10'd0);
    send_time(14'd0, 5'd7, 6'd0, 6'd0, 10'd0);
    send_time(14'd0, 5'd0, 6'd30, 6'd0, 10'd0);
    send_time(14'd0, 5'd0, 6'd0, 6'd9, 10'd450);

    // blinking dot, including a dot request on a blanked digit
    set_config(3'd3, 3'b111);
    send_time(14'd0, 5'd0, 6'd5, 6'd0, 10'd499);
    send_time(14'd0, 5'd0, 6'd5, 6'd0, 10'd500);
    send_time(14'd0, 5'd0, 6'd0, 6'd0, 10'd0);
    send_time(14'd0, 5'd0, 6'd0, 6'd0, 10'd600);
    set_config(3'd7, 3'b111);
    send_time(14'd0, 5'd0, 6'd0, 6'd0, 10'd100);
    send_time(14'd0, 5'd0, 6'd0, 6'd0, 10'd700);
    send_time(14'd3, 5'd0, 6'd0, 6'd0, 10'd0);
    send_time(14'd0, 5'd0, 6'd12, 6'd0, 10'd300);

    // every group hidden
    set_config(3'd0, 3'b000);
    send_time(14'd9999, 5'd23, 6'd59, 6'd59, 10'd999);
    send_time(14'd1, 5'd1, 6'd1, 6'd1, 10'd1);
    set_config(3'd2, 3'b111);

    // output held off while items keep coming, so the input side backs up
    in_quiet = 1'b1;
    hold_req = 1'b1;
    repeat (10) random_item();
    in_quiet = 1'b0;

    offset = $urandom_range(0, 7);
    for (int p = 0; p < 8; p++) begin
      in_quiet  = ($urandom_range(0, 3) == 0);
      out_quiet = ($urandom_range(0, 3) == 0);
      set_config(3'((p * 5 + offset) % 8),
                 {$urandom_range(0, 3) != 0, $urandom_range(0, 3) != 0,
                  $urandom_range(0, 3) != 0});
      repeat (12) random_item();
    end
    in_quiet  = 1'b0;
    out_quiet = 1'b0;
    set_config(3'd7, 3'b111);
    repeat (6) random_item();

    wait_idle();
    repeat (12) @(negedge clk);
    if (mismatch_count == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule
